@@ sv/thermal_alert_fsm_with_led_duty_core_defines.svh @@
// Assertion macros for the thermal alert core.
`ifndef THERMAL_ALERT_FSM_WITH_LED_DUTY_CORE_DEFINES_SVH
`define THERMAL_ALERT_FSM_WITH_LED_DUTY_CORE_DEFINES_SVH

// Same-cycle implication, off while reset is asserted
`define TAE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while reset is asserted
`define TAE_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/tae_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package tae_pkg;

    // Field widths
    localparam int TEMP_W   = 16;
    localparam int SPAN_W   = 15;
    localparam int RAW_W    = 16;
    localparam int DUTY_W   = 7;
    localparam int MODE_W   = 2;
    localparam int CFG_IDX_W = 2;

    // Datapath widths
    localparam int PROD_W        = RAW_W + SPAN_W;
    localparam int THR_ACC_W     = PROD_W + 1;
    localparam int DIV_W         = PROD_W + 1;
    localparam int DVSR_W        = 16;
    localparam int BITS_PER_STEP = 2;
    localparam int DIV_STEPS     = DIV_W / BITS_PER_STEP;
    localparam int CNT_W         = $clog2(DIV_STEPS);

    // Reset values and constants
    localparam logic signed [TEMP_W-1:0] BASE_RST = 16'sd5120;
    localparam logic [SPAN_W-1:0]        SPAN_RST = 15'd5120;
    localparam logic [SPAN_W-1:0]        HYST_RST = 15'd512;
    localparam logic signed [TEMP_W-1:0] THR_RST  = 16'sd7680;
    localparam logic signed [TEMP_W-1:0] TEMP_MAX = 16'sh7FFF;
    localparam logic signed [TEMP_W-1:0] TEMP_MIN = 16'sh8000;
    localparam logic [DVSR_W-1:0]        ADC_FULL   = 16'hFFFF;
    localparam logic [DVSR_W-1:0]        ONE_DEGREE = 16'd256;
    localparam logic [DUTY_W-1:0]        DUTY_FULL  = 7'd100;
    localparam logic [SPAN_W-1:0]        DUTY_MUL   = 15'd100;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_BASE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPAN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_HYST = 2'd2;

    // Mode codes as seen on the result item
    localparam logic [MODE_W-1:0] MODE_CODE_IDLE  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CODE_MON   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CODE_ALERT = 2'd2;
    localparam logic [MODE_W-1:0] MODE_CODE_COOL  = 2'd3;

    typedef struct packed {
        logic                     sample_tick;
        logic                     button_pressed;
        logic                     temperature_valid;
        logic signed [TEMP_W-1:0] temperature;
        logic                     adc_valid;
        logic [RAW_W-1:0]         adc_raw;
    } t_in_item;

    typedef struct packed {
        logic [MODE_W-1:0]        mode_now;
        logic                     drive_update;
        logic [DUTY_W-1:0]        red_duty;
        logic [DUTY_W-1:0]        green_duty;
        logic                     blue_on;
        logic signed [TEMP_W-1:0] threshold_now;
    } t_out_item;

    // Alert state machine
    typedef enum logic [3:0] {
        MODE_IDLE  = 4'b0001,
        MODE_MON   = 4'b0010,
        MODE_ALERT = 4'b0100,
        MODE_COOL  = 4'b1000
    } t_mode;

    // Micro-operations of the datapath
    typedef enum logic [3:0] {
        U_ACCEPT     = 4'd0,
        U_MUL_THR    = 4'd1,
        U_DIV_STEP   = 4'd3,
        U_THR_SET    = 4'd4,
        U_FSM        = 4'd5,
        U_DUTY_PREP  = 4'd6,
        U_DIVLD_DUTY = 4'd7,
        U_DUTY_SET   = 4'd8,
        U_EMIT       = 4'd9
    } t_uop;

    // Sequencer branch conditions
    typedef enum logic [2:0] {
        J_NEXT     = 3'd0,
        J_WAIT_IN  = 3'd1,
        J_NO_ADC   = 3'd2,
        J_DIV_LOOP = 3'd3,
        J_NO_DUTY  = 3'd4,
        J_NUM_LE0  = 3'd5,
        J_WAIT_OUT = 3'd6
    } t_jcond;

    typedef logic [3:0] t_pc;

    localparam t_pc PC_WAIT      = 4'd0;
    localparam t_pc PC_MUL       = 4'd1;
    localparam t_pc PC_THR_SET   = 4'd2;
    localparam t_pc PC_FSM       = 4'd3;
    localparam t_pc PC_DUTY_PREP = 4'd4;
    localparam t_pc PC_DUTY_LD   = 4'd5;
    localparam t_pc PC_DUTY_DIV  = 4'd6;
    localparam t_pc PC_DUTY_SET  = 4'd7;
    localparam t_pc PC_EMIT      = 4'd8;

    typedef struct packed {
        t_uop   uop;
        t_jcond jcond;
        t_pc    target;
    } t_uword;

    typedef struct packed {
        logic load;
        logic step;
    } t_div_ctl;

    // Microprogram: branch to target on the condition, else fall through; waits hold the step
    function automatic t_uword ucode(t_pc pc);
        t_uword w;
        case (pc)
            PC_WAIT:      w = '{uop: U_ACCEPT,     jcond: J_WAIT_IN,  target: PC_MUL};
            PC_MUL:       w = '{uop: U_MUL_THR,    jcond: J_NO_ADC,   target: PC_FSM};
            PC_THR_SET:   w = '{uop: U_THR_SET,    jcond: J_NEXT,     target: PC_WAIT};
            PC_FSM:       w = '{uop: U_FSM,        jcond: J_NO_DUTY,  target: PC_EMIT};
            PC_DUTY_PREP: w = '{uop: U_DUTY_PREP,  jcond: J_NUM_LE0,  target: PC_EMIT};
            PC_DUTY_LD:   w = '{uop: U_DIVLD_DUTY, jcond: J_NEXT,     target: PC_WAIT};
            PC_DUTY_DIV:  w = '{uop: U_DIV_STEP,   jcond: J_DIV_LOOP, target: PC_DUTY_DIV};
            PC_DUTY_SET:  w = '{uop: U_DUTY_SET,   jcond: J_NEXT,     target: PC_WAIT};
            PC_EMIT:      w = '{uop: U_EMIT,       jcond: J_WAIT_OUT, target: PC_WAIT};
            default:      w = '{uop: U_ACCEPT,     jcond: J_WAIT_IN,  target: PC_MUL};
        endcase
        return w;
    endfunction

    function automatic logic [MODE_W-1:0] mode_code(t_mode m);
        logic [MODE_W-1:0] c;
        unique case (m)
            MODE_IDLE:  c = MODE_CODE_IDLE;
            MODE_MON:   c = MODE_CODE_MON;
            MODE_ALERT: c = MODE_CODE_ALERT;
            MODE_COOL:  c = MODE_CODE_COOL;
            default:    c = MODE_CODE_IDLE;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

@@ sv/tae_div.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, two quotient bits per cycle while stepped
module tae_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  tae_pkg::t_div_ctl              i_ctl,
    input  logic [tae_pkg::DIV_W-1:0]      i_dividend,
    input  logic [tae_pkg::DVSR_W-1:0]     i_divisor,
    output logic [tae_pkg::DIV_W-1:0]      o_quotient,
    output logic                           o_busy
);
    import tae_pkg::*;

    logic [DIV_W-1:0]  r_quo;
    logic [DVSR_W-1:0] r_rem;
    logic [DVSR_W-1:0] r_div;
    logic [CNT_W-1:0]  r_cnt;

    logic [DIV_W-1:0]  w_quo;
    logic [DVSR_W-1:0] w_rem;
    logic [DVSR_W:0]   w_sh;
    logic [DVSR_W+1:0] w_trial;

    // Shift in the next dividend bit, keep the difference when it does not go negative
    always_comb begin
        w_quo   = r_quo;
        w_rem   = r_rem;
        w_sh    = '0;
        w_trial = '0;
        for (int i = 0; i < BITS_PER_STEP; i++) begin
            w_sh    = {w_rem, w_quo[DIV_W-1]};
            w_trial = {1'b0, w_sh} - {2'b00, r_div};
            w_rem   = w_trial[DVSR_W+1] ? w_sh[DVSR_W-1:0] : w_trial[DVSR_W-1:0];
            w_quo   = {w_quo[DIV_W-2:0], ~w_trial[DVSR_W+1]};
        end
    end

    // Step count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_ctl.load) begin
            r_cnt <= CNT_W'(DIV_STEPS - 1);
        end else if (i_ctl.step && (r_cnt != '0)) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    // Partial remainder and quotient
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (i_ctl.step) begin
            r_quo <= w_quo;
            r_rem <= w_rem;
        end
    end

    assign o_quotient = r_quo;
    assign o_busy     = (r_cnt != '0);

endmodule

`default_nettype wire

@@ sv/thermal_alert_fsm_with_led_duty_core.sv @@
// Steps per item: accept, multiply, a threshold reload when a ticked item has a valid ADC
// sample, the mode update and, when a duty is due and the temperature is above base, the
// serial duty division; then the result is registered. One item at a time: the next item
// is taken the cycle after its result is registered, and the result step waits while the
// consumer holds the previous result.
// Reset (synchronous, active low): control and configuration registers to defaults, mode idle, threshold 30 deg C.
`timescale 1ns / 1ps
`default_nettype none
`include "thermal_alert_fsm_with_led_duty_core_defines.svh"

module thermal_alert_fsm_with_led_duty_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  tae_pkg::t_in_item                 i_in,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output tae_pkg::t_out_item                o_out,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [tae_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [tae_pkg::TEMP_W-1:0]        i_cfg_data
);
    import tae_pkg::*;

    // Configuration and state
    logic signed [TEMP_W-1:0] r_base;
    logic [SPAN_W-1:0]        r_span_cfg;
    logic [SPAN_W-1:0]        r_hyst;
    t_mode                    r_mode;
    logic signed [TEMP_W-1:0] r_thr;

    // Sequencer and datapath
    t_pc                      r_pc;
    t_pc                      n_pc;
    t_in_item                 r_item;
    logic [PROD_W-1:0]        r_prod;
    logic [DVSR_W-1:0]        r_dspan;
    logic [DUTY_W-1:0]        r_red;
    t_out_item                r_out;
    logic                     r_out_valid;

    t_uword                   w_word;
    logic                     w_in_acc;
    logic                     w_out_free;
    logic signed [TEMP_W:0]   w_base_x;
    logic signed [TEMP_W:0]   w_thr_x;
    logic signed [TEMP_W:0]   w_temp_x;
    logic signed [TEMP_W:0]   w_num;
    logic signed [TEMP_W:0]   w_span_raw;
    logic [DVSR_W-1:0]        w_span;
    logic                     w_num_le0;
    logic [RAW_W-1:0]         w_mul_a;
    logic [SPAN_W-1:0]        w_mul_b;
    logic [PROD_W-1:0]        w_prod;
    logic [THR_ACC_W-1:0]     w_thr_acc;
    logic [SPAN_W-1:0]        w_thr_q;
    logic signed [TEMP_W:0]   w_thr_sum;
    logic signed [TEMP_W-1:0] w_thr_sat;
    logic signed [TEMP_W:0]   w_low;
    logic                     w_below;
    logic                     w_at_thr;
    t_mode                    w_mode_fsm;
    logic                     w_duty_go;
    logic [DUTY_W-1:0]        w_duty;
    t_out_item                w_emit;
    t_div_ctl                 w_div_ctl;
    logic [DIV_W-1:0]         w_quo;
    logic                     w_div_busy;

    // Control word for the current step
    assign w_word      = ucode(r_pc);
    assign o_in_ready  = (w_word.uop == U_ACCEPT);
    assign o_cfg_ready = 1'b1;
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_out_free  = !r_out_valid || i_out_ready;

    // Sign-extended operands
    assign w_base_x   = {r_base[TEMP_W-1], r_base};
    assign w_thr_x    = {r_thr[TEMP_W-1], r_thr};
    assign w_temp_x   = {r_item.temperature[TEMP_W-1], r_item.temperature};
    assign w_num      = w_temp_x - w_base_x;
    assign w_span_raw = w_thr_x - w_base_x;
    assign w_num_le0  = w_num[TEMP_W] || (w_num == '0);
    assign w_span     = (w_span_raw[TEMP_W] || (w_span_raw[DVSR_W-1:0] < ONE_DEGREE))
                        ? ONE_DEGREE : w_span_raw[DVSR_W-1:0];

    // Shared multiplier: raw * span for the threshold, excess * 100 for the duty
    assign w_mul_a = (w_word.uop == U_MUL_THR) ? r_item.adc_raw : w_num[RAW_W-1:0];
    assign w_mul_b = (w_word.uop == U_MUL_THR) ? r_span_cfg : DUTY_MUL;
    assign w_prod  = PROD_W'(w_mul_a) * PROD_W'(w_mul_b);

    // Divide by 65535: floor(x / (2^16 - 1)) = (x + (x >> 16) + 1) >> 16 for this range
    assign w_thr_acc = THR_ACC_W'(r_prod) + THR_ACC_W'(r_prod[PROD_W-1:RAW_W])
                       + THR_ACC_W'(1);
    assign w_thr_q   = w_thr_acc[RAW_W+SPAN_W-1:RAW_W];

    // Threshold = base + quotient, saturated to 16 bits
    assign w_thr_sum = w_base_x + $signed({2'b00, w_thr_q});
    assign w_thr_sat = (w_thr_sum[TEMP_W] != w_thr_sum[TEMP_W-1])
                       ? (w_thr_sum[TEMP_W] ? TEMP_MIN : TEMP_MAX)
                       : w_thr_sum[TEMP_W-1:0];

    // Alert comparisons
    assign w_low    = w_thr_x - $signed({2'b00, r_hyst});
    assign w_below  = (w_temp_x < w_low);
    assign w_at_thr = (w_temp_x >= w_thr_x);

    // Mode transition
    always_comb begin
        w_mode_fsm = r_mode;
        if (r_item.button_pressed) begin
            w_mode_fsm = (r_mode == MODE_IDLE) ? MODE_MON : MODE_IDLE;
        end else if (r_item.sample_tick && r_item.temperature_valid) begin
            unique case (r_mode)
                MODE_IDLE: begin
                    w_mode_fsm = MODE_IDLE;
                end
                MODE_MON: begin
                    if (w_at_thr) w_mode_fsm = MODE_ALERT;
                end
                MODE_ALERT: begin
                    if (w_below) w_mode_fsm = MODE_COOL;
                end
                MODE_COOL: begin
                    if (w_below) begin
                        w_mode_fsm = MODE_MON;
                    end else if (w_at_thr) begin
                        w_mode_fsm = MODE_ALERT;
                    end
                end
                default: begin
                    w_mode_fsm = MODE_IDLE;
                end
            endcase
        end
    end

    assign w_duty_go = r_item.sample_tick && r_item.temperature_valid &&
                       ((w_mode_fsm == MODE_MON) || (w_mode_fsm == MODE_COOL));

    // Duty clamp
    assign w_duty = ((|w_quo[DIV_W-1:DUTY_W]) || (w_quo[DUTY_W-1:0] > DUTY_FULL))
                    ? DUTY_FULL : w_quo[DUTY_W-1:0];

    // Result item
    always_comb begin
        w_emit               = '0;
        w_emit.mode_now      = mode_code(r_mode);
        w_emit.drive_update  = r_item.sample_tick;
        w_emit.threshold_now = r_thr;
        if (r_item.sample_tick) begin
            if (r_mode == MODE_ALERT) begin
                w_emit.red_duty = DUTY_FULL;
            end else if ((r_mode == MODE_MON) || (r_mode == MODE_COOL)) begin
                w_emit.red_duty   = r_red;
                w_emit.green_duty = DUTY_FULL - r_red;
                w_emit.blue_on    = (r_mode == MODE_COOL);
            end
        end
    end

    // Serial divider for the duty
    assign w_div_ctl.load = (w_word.uop == U_DIVLD_DUTY);
    assign w_div_ctl.step = (w_word.uop == U_DIV_STEP);

    tae_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_div_ctl),
        .i_dividend ({1'b0, r_prod}),
        .i_divisor  (r_dspan),
        .o_quotient (w_quo),
        .o_busy     (w_div_busy)
    );

    // Step counter branch
    always_comb begin
        unique case (w_word.jcond)
            J_NEXT:     n_pc = t_pc'(r_pc + 1'b1);
            J_WAIT_IN:  n_pc = w_in_acc ? w_word.target : r_pc;
            J_NO_ADC:   n_pc = (r_item.sample_tick && r_item.adc_valid)
                               ? t_pc'(r_pc + 1'b1) : w_word.target;
            J_DIV_LOOP: n_pc = w_div_busy ? w_word.target : t_pc'(r_pc + 1'b1);
            J_NO_DUTY:  n_pc = w_duty_go ? t_pc'(r_pc + 1'b1) : w_word.target;
            J_NUM_LE0:  n_pc = w_num_le0 ? w_word.target : t_pc'(r_pc + 1'b1);
            J_WAIT_OUT: n_pc = w_out_free ? w_word.target : r_pc;
            default:    n_pc = PC_WAIT;
        endcase
    end

    // Control state, configuration and alert state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= PC_WAIT;
            r_base      <= BASE_RST;
            r_span_cfg  <= SPAN_RST;
            r_hyst      <= HYST_RST;
            r_mode      <= MODE_IDLE;
            r_thr       <= THR_RST;
            r_out_valid <= 1'b0;
        end else begin
            r_pc <= n_pc;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_IDX_BASE: r_base     <= i_cfg_data;
                    CFG_IDX_SPAN: r_span_cfg <= i_cfg_data[SPAN_W-1:0];
                    CFG_IDX_HYST: r_hyst     <= i_cfg_data[SPAN_W-1:0];
                    default: ;
                endcase
            end
            if (w_word.uop == U_THR_SET) r_thr <= w_thr_sat;
            if (w_word.uop == U_FSM) r_mode <= w_mode_fsm;
            if ((w_word.uop == U_EMIT) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Item payload and datapath registers
    always_ff @(posedge i_clk) begin
        if (w_in_acc) r_item <= i_in;
        unique case (w_word.uop)
            U_MUL_THR: begin
                r_prod <= w_prod;
            end
            U_FSM: begin
                r_red <= '0;
            end
            U_DUTY_PREP: begin
                r_prod  <= w_prod;
                r_dspan <= w_span;
            end
            U_DUTY_SET: begin
                r_red <= w_duty;
            end
            U_EMIT: begin
                if (w_out_free) r_out <= w_emit;
            end
            default: ;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Checks
    `TAE_ASSERT_NXT(a_accept_runs, i_clk, i_rst_n, w_in_acc, r_pc == PC_MUL, "accepted item did not start the program")
    `TAE_ASSERT_IMP(a_red_range, i_clk, i_rst_n, o_out_valid, o_out.red_duty <= DUTY_FULL, "red duty above full scale")
    `TAE_ASSERT_IMP(a_duty_sum, i_clk, i_rst_n, o_out_valid && o_out.drive_update && (o_out.mode_now == MODE_CODE_MON || o_out.mode_now == MODE_CODE_COOL), (8'(o_out.red_duty) + 8'(o_out.green_duty)) == 8'd100, "red and green do not add to full scale")
    `TAE_ASSERT_IMP(a_no_drive, i_clk, i_rst_n, o_out_valid && !o_out.drive_update, (o_out.red_duty == '0) && (o_out.green_duty == '0) && !o_out.blue_on, "drive values set without a sample tick")

endmodule

`default_nettype wire
